// ===== design/lfu_pkg.sv =====
// Package: widths, word types and constants for the LFU cache table.
package lfu_pkg;
  localparam int ENTRIES     = 64;
  localparam int COUNT_WIDTH = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W       = $clog2(ENTRIES + 1);
  localparam int CAP_W       = 7;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]       key;
    logic [VAL_W-1:0]       value;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [IDX_W-1:0]       rank;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);
endpackage

// ===== design/lfu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
  parameter int W  = 8,
  parameter int D  = 64,
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== design/lfu_cache_table_unit.sv =====
// LFU cache table: one word in, one result word out, entries held in one RAM.
// The scan is followed by a rank-update pass when an entry is touched or evicted;
// both passes walk the RAM one entry a cycle.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset: synchronous active-low rst_n clears valid bits, occupancy, control,
// and sets cache_capacity to 64. The result strobe cannot be stalled.
module lfu_cache_table_unit
  import lfu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_data,
  output logic             out_valid,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [OCC_W-1:0]  cnt_r, cnt_nxt;
  logic              p_vld_r;
  logic [IDX_W-1:0]  p_idx_r;
  in_word_t          req_r;

  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  f_idx_r, f_idx_nxt;
  ent_t              f_ent_r, f_ent_nxt;
  logic              v_ok_r, v_ok_nxt;
  logic [IDX_W-1:0]  v_idx_r, v_idx_nxt;
  ent_t              v_ent_r, v_ent_nxt;
  logic              fr_ok_r, fr_ok_nxt;
  logic [IDX_W-1:0]  fr_idx_r, fr_idx_nxt;

  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  ent_t              tgt_ent_r, tgt_ent_nxt;
  logic [IDX_W-1:0]  dec_rank_r, dec_rank_nxt;
  out_word_t         res_r, res_nxt;
  logic              ov_r, ov_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  ent_t              ram_wdata, ram_rdata;
  logic [ENT_W-1:0]  ram_rbits;

  logic              rd_more, last;
  logic [31:0]       cap_eff;
  logic [COUNT_WIDTH-1:0] f_cnt_inc;

  lfu_ram #(.W(ENT_W), .D(ENTRIES), .AW(IDX_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = ent_t'(ram_rbits);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = res_r;

  assign rd_more   = (cnt_r < OCC_W'(ENTRIES));
  assign ram_raddr = cnt_r[IDX_W-1:0];
  assign ram_re    = ((state_r == S_SCAN) || (state_r == S_UPD)) && rd_more;
  assign last      = p_vld_r && (p_idx_r == IDX_W'(ENTRIES - 1));
  assign cap_eff   = (32'(cap_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_r);
  assign f_cnt_inc = (f_ent_r.cnt == COUNT_MAX) ? f_ent_r.cnt : f_ent_r.cnt + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    valid_nxt    = valid_r;
    cnt_nxt      = rd_more ? cnt_r + 1'b1 : cnt_r;
    hit_nxt      = hit_r;
    f_idx_nxt    = f_idx_r;
    f_ent_nxt    = f_ent_r;
    v_ok_nxt     = v_ok_r;
    v_idx_nxt    = v_idx_r;
    v_ent_nxt    = v_ent_r;
    fr_ok_nxt    = fr_ok_r;
    fr_idx_nxt   = fr_idx_r;
    tgt_nxt      = tgt_r;
    tgt_ent_nxt  = tgt_ent_r;
    dec_rank_nxt = dec_rank_r;
    res_nxt      = res_r;
    ov_nxt       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = p_idx_r;
    ram_wdata    = ram_rdata;

    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = S_SCAN;
          hit_nxt   = 1'b0;
          v_ok_nxt  = 1'b0;
          fr_ok_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (p_vld_r) begin
          if (!valid_r[p_idx_r]) begin
            if (!fr_ok_r) begin
              fr_ok_nxt  = 1'b1;
              fr_idx_nxt = p_idx_r;
            end
          end else begin
            if (ram_rdata.key == req_r.key) begin
              hit_nxt   = 1'b1;
              f_idx_nxt = p_idx_r;
              f_ent_nxt = ram_rdata;
            end
            // smallest count, least recent among equal counts
            if (!v_ok_r || (ram_rdata.cnt < v_ent_r.cnt) ||
                ((ram_rdata.cnt == v_ent_r.cnt) && (ram_rdata.rank < v_ent_r.rank))) begin
              v_ok_nxt  = 1'b1;
              v_idx_nxt = p_idx_r;
              v_ent_nxt = ram_rdata;
            end
          end
          if (last) begin
            state_nxt = S_DEC;
          end
        end
      end
      S_DEC: begin
        cnt_nxt          = '0;
        res_nxt          = '0;
        res_nxt.hit      = hit_r;
        state_nxt        = S_IDLE;
        ov_nxt           = 1'b1;
        if (req_r.op == OP_GET) begin
          if (hit_r) begin
            res_nxt.read_value = f_ent_r.value;
            tgt_nxt            = f_idx_r;
            tgt_ent_nxt        = f_ent_r;
            tgt_ent_nxt.cnt    = f_cnt_inc;
            tgt_ent_nxt.rank   = IDX_W'(occ_r - 1'b1);
            dec_rank_nxt       = f_ent_r.rank;
            state_nxt          = S_UPD;
            ov_nxt             = 1'b0;
          end
        end else if (cap_eff != 32'd0) begin
          if (hit_r) begin
            tgt_nxt           = f_idx_r;
            tgt_ent_nxt       = f_ent_r;
            tgt_ent_nxt.value = req_r.value;
            tgt_ent_nxt.cnt   = f_cnt_inc;
            tgt_ent_nxt.rank  = IDX_W'(occ_r - 1'b1);
            dec_rank_nxt      = f_ent_r.rank;
            state_nxt         = S_UPD;
            ov_nxt            = 1'b0;
          end else if (((32'(occ_r) >= cap_eff) || !fr_ok_r) && v_ok_r) begin
            res_nxt.evicted     = 1'b1;
            res_nxt.evicted_key = v_ent_r.key;
            tgt_nxt             = v_idx_r;
            tgt_ent_nxt.key     = req_r.key;
            tgt_ent_nxt.value   = req_r.value;
            tgt_ent_nxt.cnt     = COUNT_WIDTH'(1);
            tgt_ent_nxt.rank    = IDX_W'(occ_r - 1'b1);
            dec_rank_nxt        = v_ent_r.rank;
            state_nxt           = S_UPD;
            ov_nxt              = 1'b0;
          end else begin
            // free slot: single write, no rank shuffle
            ram_we              = 1'b1;
            ram_waddr           = fr_idx_r;
            ram_wdata.key       = req_r.key;
            ram_wdata.value     = req_r.value;
            ram_wdata.cnt       = COUNT_WIDTH'(1);
            ram_wdata.rank      = IDX_W'(occ_r);
            valid_nxt[fr_idx_r] = 1'b1;
            occ_nxt             = occ_r + 1'b1;
          end
        end
      end
      S_UPD: begin
        if (p_vld_r) begin
          if (p_idx_r == tgt_r) begin
            ram_we    = 1'b1;
            ram_wdata = tgt_ent_r;
          end else if (valid_r[p_idx_r] && (ram_rdata.rank > dec_rank_r)) begin
            ram_we         = 1'b1;
            ram_wdata.rank = ram_rdata.rank - 1'b1;
          end
          if (last) begin
            state_nxt = S_IDLE;
            ov_nxt    = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r   <= CAP_RESET;
      occ_r   <= '0;
      valid_r <= '0;
      cnt_r   <= '0;
      p_vld_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      p_vld_r <= ram_re;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r    <= ram_raddr;
    hit_r      <= hit_nxt;
    f_idx_r    <= f_idx_nxt;
    f_ent_r    <= f_ent_nxt;
    v_ok_r     <= v_ok_nxt;
    v_idx_r    <= v_idx_nxt;
    v_ent_r    <= v_ent_nxt;
    fr_ok_r    <= fr_ok_nxt;
    fr_idx_r   <= fr_idx_nxt;
    tgt_r      <= tgt_nxt;
    tgt_ent_r  <= tgt_ent_nxt;
    dec_rank_r <= dec_rank_nxt;
    res_r      <= res_nxt;
    if (start && !busy) begin
      req_r <= in_data;
    end
  end
endmodule

// ===== tb/tb_lfu_cache_table_unit.sv =====
// Testbench for the LFU cache table: directed and random get/put words checked against a model.
`timescale 1ns / 100ps

module tb_lfu_cache_table_unit;
  import lfu_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_word_t         in_data = '0;
  logic             out_valid;
  out_word_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lfu_cache_table_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // cache model state
  logic                   m_valid [ENTRIES];
  logic [KEY_W-1:0]       m_key   [ENTRIES];
  logic [VAL_W-1:0]       m_val   [ENTRIES];
  logic [COUNT_WIDTH-1:0] m_cnt   [ENTRIES];
  int unsigned            m_rank  [ENTRIES];
  int unsigned            m_occ;
  logic [CAP_W-1:0]       m_cap;

  out_word_t expected_results[$];
  int        mismatches = 0;
  bit        idle_gaps = 1'b1;
  logic [KEY_W-1:0] key_pool [16];

  function automatic void model_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      m_valid[i] = 1'b0; m_key[i] = '0; m_val[i] = '0; m_cnt[i] = '0; m_rank[i] = 0;
    end
    m_occ = 0;
    m_cap = CAP_RESET;
  endfunction

  function automatic void drop_ranks_above(int unsigned r);
    for (int i = 0; i < ENTRIES; i++)
      if (m_valid[i] && m_rank[i] > r) m_rank[i]--;
  endfunction

  function automatic void model_use(int s);
    if (m_cnt[s] != COUNT_MAX) m_cnt[s]++;
    drop_ranks_above(m_rank[s]);
    m_rank[s] = m_occ - 1;
  endfunction

  function automatic out_word_t predict_lookup(in_word_t w);
    out_word_t   r;
    int unsigned eff_cap;
    int          found, free_slot, victim, slot;
    r = '0;
    found = -1; free_slot = -1; victim = -1;
    eff_cap = (m_cap < ENTRIES) ? m_cap : ENTRIES;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!m_valid[i]) begin
        if (free_slot < 0) free_slot = i;
      end else begin
        if (m_key[i] == w.key) found = i;
        if (victim < 0 || m_cnt[i] < m_cnt[victim] ||
            (m_cnt[i] == m_cnt[victim] && m_rank[i] < m_rank[victim]))
          victim = i;
      end
    end
    r.hit = (found >= 0);
    if (w.op == OP_GET) begin
      if (found >= 0) begin
        model_use(found);
        r.read_value = m_val[found];
      end
    end else if (eff_cap != 0) begin
      if (found >= 0) begin
        m_val[found] = w.value;
        model_use(found);
      end else begin
        slot = free_slot;
        if ((m_occ >= eff_cap || free_slot < 0) && victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = m_key[victim];
          m_valid[victim] = 1'b0;
          m_occ--;
          drop_ranks_above(m_rank[victim]);
          slot = victim;
        end
        if (slot >= 0) begin
          m_valid[slot] = 1'b1; m_key[slot] = w.key; m_val[slot] = w.value;
          m_cnt[slot] = 1; m_rank[slot] = m_occ;
          m_occ++;
        end
      end
    end
    return r;
  endfunction

  // result checker: strobe cannot be held off, sample every cycle
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", out_data);
      end else begin
        out_word_t e;
        e = expected_results.pop_front();
        if (out_data.hit !== e.hit || out_data.read_value !== e.read_value ||
            out_data.evicted !== e.evicted || out_data.evicted_key !== e.evicted_key) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d val=%0d ev=%0d evk=%0d, got hit=%0d val=%0d ev=%0d evk=%0d",
                     e.hit, e.read_value, e.evicted, e.evicted_key, out_data.hit,
                     out_data.read_value, out_data.evicted, out_data.evicted_key);
        end
      end
    end
  end

  // start stays high after the accepting edge; busy blocks a second accept until the
  // next word or the drain drops it
  task automatic send_word(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    in_word_t w;
    w.op = op; w.key = k; w.value = v;
    if (idle_gaps)
      while ($urandom_range(99) < 20) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start   <= 1'b1;
    in_data <= w;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    expected_results.push_back(predict_lookup(w));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * ENTRIES + 10) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_cap = c;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    return ($urandom_range(9) < 8) ? key_pool[$urandom_range(15)] : $urandom();
  endfunction

  task automatic test_directed();
    send_word(OP_GET, 32'h0, 32'h0);               // miss on empty store
    send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678); // update present key
    send_word(OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_GET, 32'h0000_0005, 32'h0);
  endtask

  task automatic test_small_capacity();
    write_capacity(2);                           // below occupancy: one evict per insert
    send_word(OP_PUT, 32'd10, 32'd100);
    send_word(OP_PUT, 32'd11, 32'd110);
    send_word(OP_GET, 32'd10, 32'd0);
    send_word(OP_PUT, 32'd12, 32'd120);          // evicts key 11, the only entry with count one
    send_word(OP_GET, 32'd11, 32'd0);
    write_capacity(0);                           // puts ignored
    send_word(OP_PUT, 32'd12, 32'd999);
    send_word(OP_PUT, 32'd13, 32'd130);
    send_word(OP_GET, 32'd12, 32'd0);
    write_capacity(7'h7F);                       // above entries
    send_word(OP_PUT, 32'd14, 32'd140);
  endtask

  task automatic test_fill_and_evict();
    write_capacity(64);
    for (int i = 0; i < 70; i++) send_word(OP_PUT, 32'h1000 + i, $urandom());
    for (int i = 0; i < 8; i++) send_word(OP_GET, 32'h1000 + 60 + i, 32'd0);
    for (int i = 0; i < 6; i++) send_word(OP_PUT, 32'h2000 + i, $urandom());
  endtask

  task automatic test_frequency_order();
    // a heavily used entry survives inserts into a small store
    write_capacity(3);
    idle_gaps = 1'b0;
    send_word(OP_PUT, 32'hABCD, 32'd1);
    for (int i = 0; i < 20; i++) send_word(OP_GET, 32'hABCD, 32'd0);
    idle_gaps = 1'b1;
    send_word(OP_PUT, 32'h1, 32'd1);
    send_word(OP_PUT, 32'h2, 32'd2);
    send_word(OP_PUT, 32'h3, 32'd3);
    send_word(OP_GET, 32'hABCD, 32'd0);
  endtask

  task automatic test_random();
    logic [CAP_W-1:0] caps [5] = '{7'd4, 7'd1, 7'd16, 7'd0, 7'd64};
    for (int p = 0; p < 5; p++) begin
      write_capacity(caps[p]);
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      idle_gaps = (p != 2);                      // one phase with back-to-back words
      for (int i = 0; i < 205; i++)
        send_word(1'($urandom_range(1)), pick_key(), $urandom());
    end
    idle_gaps = 1'b1;
  endtask

  initial begin
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_capacity();
    test_fill_and_evict();
    test_random();
    test_frequency_order();
    wait_drain();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
